// ===== sv/hcas_pkg.sv =====
// shared constants, types and helper functions for the hard clip antiderivative shaper
package hcas_pkg;

    localparam int FRAC_BITS    = 20;
    localparam int SAMPLE_WIDTH = 24;
    localparam int OUT_WIDTH    = 22;
    localparam int WORK_W       = 36;
    localparam int DEN_W        = SAMPLE_WIDTH + 1;
    localparam int DIV_W        = 56;
    localparam int CNT_W        = $clog2(DIV_W);
    localparam int PROD_W       = 2 * DEN_W;
    localparam int TOL_W        = 20;
    localparam int CFG_W        = 20;
    localparam int CFG_IDX_W    = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE  = 2'd1;

    // order modes
    localparam logic [1:0] MODE_PASS   = 2'd0;
    localparam logic [1:0] MODE_FIRST  = 2'd1;
    localparam logic [1:0] MODE_SECOND = 2'd2;

    localparam logic [1:0]       MODE_RESET = MODE_FIRST;
    localparam logic [TOL_W-1:0] TOL_RESET  = 20'd10;

    // floor(one*one/3), the constant term of the outer second antiderivative
    localparam logic [PROD_W-1:0] AD2_C3 =
        PROD_W'((64'd1 << (2 * FRAC_BITS)) / 64'd3);
    // ceil(2^24/6), exact reciprocal of six for values below 2^22
    localparam logic [DEN_W-1:0] RECIP6 = DEN_W'(((64'd1 << 24) + 64'd5) / 64'd6);
    localparam int RECIP6_SHIFT = 24;

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [WORK_W-1:0]       work_t;
    typedef logic signed [DEN_W-1:0]        den_t;
    typedef logic signed [OUT_WIDTH-1:0]    out_t;
    typedef logic signed [31:0]             acc32_t;

    localparam work_t ONE_W = work_t'(64'd1 << FRAC_BITS);

    // rounded midpoint, ties away from zero
    function automatic sample_t mid_fn(sample_t a, sample_t b);
        den_t             s;
        logic [DEN_W-1:0] m;
        logic [DEN_W-1:0] h;
        s = den_t'(a) + den_t'(b);
        m = s[DEN_W-1] ? DEN_W'(-s) : DEN_W'(s);
        h = (m + DEN_W'(1)) >> 1;
        return s[DEN_W-1] ? sample_t'(-h[SAMPLE_WIDTH-1:0]) : sample_t'(h[SAMPLE_WIDTH-1:0]);
    endfunction

    function automatic out_t clip_fn(work_t v);
        out_t r;
        if (v > ONE_W)
            r = out_t'(ONE_W);
        else if (v < -ONE_W)
            r = out_t'(-ONE_W);
        else
            r = v[OUT_WIDTH-1:0];
        return r;
    endfunction

    function automatic work_t sat32_fn(work_t v);
        work_t r;
        if (v > work_t'(64'sd2147483647))
            r = work_t'(64'sd2147483647);
        else if (v < work_t'(-64'sd2147483648))
            r = work_t'(-64'sd2147483648);
        else
            r = v;
        return r;
    endfunction

    function automatic logic is_small_fn(den_t d, logic [TOL_W-1:0] tol);
        logic [DEN_W-1:0] m;
        m = d[DEN_W-1] ? DEN_W'(-d) : DEN_W'(d);
        return m <= DEN_W'(tol);
    endfunction

endpackage

// ===== sv/hard_clip_antiderivative_shaper_core.sv =====
// Antialiased hard clipper: one shared multiplier and one shared bit-serial divider under a
// sequencer. The block takes one word at a time; in_stall is high from acceptance until the
// result has moved into the output register, which then waits for the consumer while the next
// word may already be taken. The restoring divider runs one quotient bit per cycle, and the number
// of divisions sets the latency: pass-through needs none, first order at most one, second order one
// when samples sit close and two in the common case, and up to three when the midpoint fallback
// needs its own two divisions.
module hard_clip_antiderivative_shaper_core
    import hcas_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [OUT_WIDTH-1:0] sample_out
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISPATCH,
        ST_A1_MUL, ST_A1_FIN,
        ST_A2_SQ, ST_A2_B, ST_A2_C, ST_A2_D,
        ST_DV_INIT, ST_DV_RUN, ST_DV_FIN,
        ST_M1_A, ST_M1_Q,
        ST_M2_A, ST_M2_D1AD, ST_M2_D1Q, ST_M2_B, ST_M2_C,
        ST_M2_E, ST_M2_F, ST_M2_G, ST_M2_FQ,
        ST_WAIT_OUT
    } state_t;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [1:0]       mode_reg, mode_next;
    logic [TOL_W-1:0] tol_reg, tol_next;

    sample_t s_reg, s_next, x1_reg, x1_next, x2_reg, x2_next;
    sample_t v_reg, v_next, xb_reg, xb_next;
    acc32_t  ad1p_reg, ad1p_next, ad2p_reg, ad2p_next, ddp_reg, ddp_next;
    acc32_t  anew_reg, anew_next, d1_reg, d1_next, t_reg, t_next;
    den_t    dl_reg, dl_next, den_reg, den_next;
    work_t   ad_reg, ad_next, q_reg, q_next, num_reg, num_next;
    logic    k21_reg, k21_next, neg_reg, neg_next;
    logic [DEN_W-1:0]  dm_reg, dm_next, rem_reg, rem_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] prod_reg, prod_next;
    out_t    res_reg, res_next, out_reg, out_next;
    logic    out_valid_reg, out_valid_next;

    // datapath helpers
    logic [SAMPLE_WIDTH-1:0] m_v;
    logic [DEN_W-1:0]        mul_a, mul_b;
    logic [PROD_W-1:0]       mul_p;
    logic [PROD_W-1:0]       sq_sum, y_sum, a1_sum, b2_sum;
    work_t                   a1_val, a2_big, a2_small;
    den_t                    diff1, diff2, dl_c;
    sample_t                 mid_s_x1, mid_s_x2, mid_xb_x1;
    logic [WORK_W-1:0]       num_mag, q_mag;
    logic [DIV_W:0]          num_shift;
    logic [DEN_W-1:0]        dm_c;
    logic [DEN_W:0]          trial;
    work_t                   q_sat, t_sum;

    assign m_v       = v_reg[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-v_reg) : SAMPLE_WIDTH'(v_reg);
    assign mul_p     = mul_a * mul_b;
    assign sq_sum    = prod_reg + (PROD_W'(1) << (FRAC_BITS - 1));
    assign y_sum     = prod_reg + (PROD_W'(3) << FRAC_BITS);
    assign a1_sum    = prod_reg + (PROD_W'(1) << FRAC_BITS);
    assign b2_sum    = prod_reg - (PROD_W'(m_v) << FRAC_BITS) + AD2_C3
                       + (PROD_W'(1) << FRAC_BITS);
    assign a1_val    = (work_t'(m_v) <= ONE_W)
                       ? work_t'(a1_sum >> (FRAC_BITS + 1))
                       : work_t'(m_v) - (ONE_W >>> 1);
    assign a2_big    = v_reg[SAMPLE_WIDTH-1] ? -work_t'(b2_sum >> (FRAC_BITS + 1))
                                             : work_t'(b2_sum >> (FRAC_BITS + 1));
    assign a2_small  = v_reg[SAMPLE_WIDTH-1] ? -work_t'(prod_reg >> RECIP6_SHIFT)
                                             : work_t'(prod_reg >> RECIP6_SHIFT);
    assign diff1     = den_t'(s_reg) - den_t'(x1_reg);
    assign diff2     = den_t'(s_reg) - den_t'(x2_reg);
    assign dl_c      = den_t'(xb_reg) - den_t'(x1_reg);
    assign mid_s_x1  = mid_fn(s_reg, x1_reg);
    assign mid_s_x2  = mid_fn(s_reg, x2_reg);
    assign mid_xb_x1 = mid_fn(xb_reg, x1_reg);
    assign num_mag   = num_reg[WORK_W-1] ? WORK_W'(-num_reg) : WORK_W'(num_reg);
    assign num_shift = k21_reg ? ((DIV_W+1)'(num_mag) << (FRAC_BITS + 1))
                               : ((DIV_W+1)'(num_mag) << FRAC_BITS);
    assign dm_c      = den_reg[DEN_W-1] ? DEN_W'(-den_reg) : DEN_W'(den_reg);
    assign trial     = {rem_reg, dvd_reg[DIV_W-1]} - {1'b0, dm_reg};
    assign q_mag     = (|dvd_reg[DIV_W-1:33]) ? (WORK_W'(1) << 32) : WORK_W'(dvd_reg[32:0]);
    assign q_sat     = sat32_fn(q_reg);
    assign t_sum     = sat32_fn(ad_reg + work_t'(t_reg));

    // shared multiplier operand select
    always_comb
    begin
        unique case (state_reg)
            ST_A2_B:
            begin
                mul_a = sq_sum[FRAC_BITS+DEN_W-1:FRAC_BITS];
                mul_b = DEN_W'(m_v);
            end
            ST_A2_C:
            begin
                mul_a = y_sum[FRAC_BITS+DEN_W-1:FRAC_BITS];
                mul_b = RECIP6;
            end
            default:
            begin
                mul_a = DEN_W'(m_v);
                mul_b = DEN_W'(m_v);
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;   ret_next  = ret_reg;
        mode_next  = mode_reg;    tol_next  = tol_reg;
        s_next     = s_reg;       x1_next   = x1_reg;    x2_next   = x2_reg;
        v_next     = v_reg;       xb_next   = xb_reg;
        ad1p_next  = ad1p_reg;    ad2p_next = ad2p_reg;  ddp_next  = ddp_reg;
        anew_next  = anew_reg;    d1_next   = d1_reg;    t_next    = t_reg;
        dl_next    = dl_reg;      den_next  = den_reg;
        ad_next    = ad_reg;      q_next    = q_reg;     num_next  = num_reg;
        k21_next   = k21_reg;     neg_next  = neg_reg;
        dm_next    = dm_reg;      rem_next  = rem_reg;   dvd_next  = dvd_reg;
        cnt_next   = cnt_reg;     prod_next = prod_reg;
        res_next   = res_reg;     out_next  = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (cfg_wr_en)
        begin
            if (cfg_index == REG_ORDER_MODE)
                mode_next = cfg_data[1:0];
            else if (cfg_index == REG_TOLERANCE)
                tol_next = cfg_data[TOL_W-1:0];
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    s_next     = sample_in;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                v_next = s_reg;
                if (mode_reg == MODE_FIRST)
                begin
                    ret_next   = ST_M1_A;
                    state_next = ST_A1_MUL;
                end
                else if (mode_reg == MODE_SECOND)
                begin
                    ret_next   = ST_M2_A;
                    state_next = ST_A2_SQ;
                end
                else
                begin
                    res_next   = clip_fn(work_t'(s_reg));
                    state_next = ST_WAIT_OUT;
                end
            end
            // first antiderivative of v_reg
            ST_A1_MUL:
            begin
                prod_next  = mul_p;
                state_next = ST_A1_FIN;
            end
            ST_A1_FIN:
            begin
                ad_next    = a1_val;
                state_next = ret_reg;
            end
            // second antiderivative of v_reg
            ST_A2_SQ:
            begin
                prod_next  = mul_p;
                state_next = ST_A2_B;
            end
            ST_A2_B:
            begin
                if (work_t'(m_v) > ONE_W)
                begin
                    ad_next    = a2_big;
                    state_next = ret_reg;
                end
                else
                begin
                    prod_next  = mul_p;
                    state_next = ST_A2_C;
                end
            end
            ST_A2_C:
            begin
                // divide by six through the reciprocal
                prod_next  = mul_p;
                state_next = ST_A2_D;
            end
            ST_A2_D:
            begin
                ad_next    = a2_small;
                state_next = ret_reg;
            end
            // rounded num * 2^k / den
            ST_DV_INIT:
            begin
                neg_next = num_reg[WORK_W-1] ^ den_reg[DEN_W-1];
                dm_next  = dm_c;
                rem_next = '0;
                cnt_next = '0;
                dvd_next = num_shift[DIV_W-1:0] + DIV_W'(dm_c >> 1);
                if (dm_c == '0)
                begin
                    q_next     = '0;
                    state_next = ret_reg;
                end
                else
                    state_next = ST_DV_RUN;
            end
            ST_DV_RUN:
            begin
                if (!trial[DEN_W])
                    rem_next = trial[DEN_W-1:0];
                else
                    rem_next = {rem_reg[DEN_W-2:0], dvd_reg[DIV_W-1]};
                dvd_next = {dvd_reg[DIV_W-2:0], !trial[DEN_W]};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_W - 1))
                    state_next = ST_DV_FIN;
            end
            ST_DV_FIN:
            begin
                q_next     = neg_reg ? -work_t'(q_mag) : work_t'(q_mag);
                state_next = ret_reg;
            end
            // first order
            ST_M1_A:
            begin
                anew_next = ad_reg[31:0];
                if (is_small_fn(diff1, tol_reg))
                begin
                    res_next   = clip_fn(work_t'(mid_s_x1));
                    ad1p_next  = ad_reg[31:0];
                    x1_next    = s_reg;
                    state_next = ST_WAIT_OUT;
                end
                else
                begin
                    num_next   = ad_reg - work_t'(ad1p_reg);
                    den_next   = diff1;
                    k21_next   = 1'b0;
                    ret_next   = ST_M1_Q;
                    state_next = ST_DV_INIT;
                end
            end
            ST_M1_Q:
            begin
                res_next   = clip_fn(q_reg);
                ad1p_next  = anew_reg;
                x1_next    = s_reg;
                state_next = ST_WAIT_OUT;
            end
            // second order
            ST_M2_A:
            begin
                anew_next = ad_reg[31:0];
                if (is_small_fn(diff1, tol_reg))
                begin
                    v_next     = mid_s_x1;
                    ret_next   = ST_M2_D1AD;
                    state_next = ST_A1_MUL;
                end
                else
                begin
                    num_next   = ad_reg - work_t'(ad2p_reg);
                    den_next   = diff1;
                    k21_next   = 1'b0;
                    ret_next   = ST_M2_D1Q;
                    state_next = ST_DV_INIT;
                end
            end
            ST_M2_D1AD:
            begin
                d1_next    = ad_reg[31:0];
                state_next = ST_M2_B;
            end
            ST_M2_D1Q:
            begin
                d1_next    = q_sat[31:0];
                state_next = ST_M2_B;
            end
            ST_M2_B:
            begin
                if (!is_small_fn(diff2, tol_reg))
                begin
                    num_next   = work_t'(d1_reg) - work_t'(ddp_reg);
                    den_next   = diff2;
                    k21_next   = 1'b1;
                    ret_next   = ST_M2_FQ;
                    state_next = ST_DV_INIT;
                end
                else
                begin
                    xb_next    = mid_s_x2;
                    state_next = ST_M2_C;
                end
            end
            ST_M2_C:
            begin
                dl_next = dl_c;
                if (is_small_fn(dl_c, tol_reg))
                begin
                    res_next   = clip_fn(work_t'(mid_xb_x1));
                    ddp_next   = d1_reg;
                    x2_next    = x1_reg;
                    x1_next    = s_reg;
                    ad2p_next  = anew_reg;
                    state_next = ST_WAIT_OUT;
                end
                else
                begin
                    v_next     = xb_reg;
                    ret_next   = ST_M2_E;
                    state_next = ST_A2_SQ;
                end
            end
            ST_M2_E:
            begin
                num_next   = work_t'(ad2p_reg) - ad_reg;
                den_next   = dl_reg;
                k21_next   = 1'b0;
                ret_next   = ST_M2_F;
                state_next = ST_DV_INIT;
            end
            ST_M2_F:
            begin
                t_next     = q_sat[31:0];
                v_next     = xb_reg;
                ret_next   = ST_M2_G;
                state_next = ST_A1_MUL;
            end
            ST_M2_G:
            begin
                num_next   = t_sum;
                den_next   = dl_reg;
                k21_next   = 1'b1;
                ret_next   = ST_M2_FQ;
                state_next = ST_DV_INIT;
            end
            ST_M2_FQ:
            begin
                res_next   = clip_fn(q_reg);
                ddp_next   = d1_reg;
                x2_next    = x1_reg;
                x1_next    = s_reg;
                ad2p_next  = anew_reg;
                state_next = ST_WAIT_OUT;
            end
            ST_WAIT_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            mode_reg      <= MODE_RESET;
            tol_reg       <= TOL_RESET;
            x1_reg        <= '0;
            x2_reg        <= '0;
            ad1p_reg      <= '0;
            ad2p_reg      <= '0;
            ddp_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            mode_reg      <= mode_next;
            tol_reg       <= tol_next;
            x1_reg        <= x1_next;
            x2_reg        <= x2_next;
            ad1p_reg      <= ad1p_next;
            ad2p_reg      <= ad2p_next;
            ddp_reg       <= ddp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= s_next;
        v_reg    <= v_next;
        xb_reg   <= xb_next;
        anew_reg <= anew_next;
        d1_reg   <= d1_next;
        t_reg    <= t_next;
        dl_reg   <= dl_next;
        den_reg  <= den_next;
        ad_reg   <= ad_next;
        q_reg    <= q_next;
        num_reg  <= num_next;
        k21_reg  <= k21_next;
        neg_reg  <= neg_next;
        dm_reg   <= dm_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign sample_out = out_reg;

endmodule
